FILE: sv/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg: shared types and constants of the troubled cell indicator
// Beat formats, configuration layout, queue command format and helpers.
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int AVG_W       = 32;
    localparam int SLOPE_W     = 32;
    localparam int IND_W       = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 1;
    // jumps avg + 2*slope - avg need two extra bits plus sign headroom
    localparam int JUMP_W      = AVG_W + 3;
    localparam int MAG_W       = SLOPE_W;
    localparam int PROD_W      = MAG_W + CFG_W;
    localparam int JPROD_W     = 2 * CFG_W;
    // classification stages between acceptance and the queue push
    localparam int FRONT_STAGES = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_RATIO       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRODUCT_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] SLOPE_RATIO_RESET       = 16'd256;
    localparam logic [CFG_W-1:0] PRODUCT_THRESHOLD_RESET = 16'd429;

    localparam logic [IND_W-1:0] IND_BOUNDARY = 3'd1;

    typedef logic [1:0] seen_t;

    typedef struct packed {
        logic signed [AVG_W-1:0]   cell_average;
        logic signed [SLOPE_W-1:0] cell_slope;
        logic                      last_cell;
    } cell_beat_t;

    typedef struct packed {
        logic [IND_W-1:0] indicator;
        logic             last_result;
    } result_beat_t;

    typedef struct packed {
        logic [CFG_W-1:0] slope_ratio;
        logic [CFG_W-1:0] product_threshold;
    } cfg_t;

    // one queue entry: up to three results, in emission order
    typedef struct packed {
        logic [1:0]       count;
        logic             row_last;
        logic [IND_W-1:0] ind0;
        logic [IND_W-1:0] ind1;
        logic [IND_W-1:0] ind2;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

    function automatic logic [MAG_W-1:0] slope_mag(input logic signed [SLOPE_W-1:0] v);
        return v[SLOPE_W-1] ? (MAG_W'(~v) + MAG_W'(1)) : MAG_W'(v);
    endfunction

    function automatic logic [JUMP_W-1:0] jump_mag(input logic signed [JUMP_W-1:0] v);
        return v[JUMP_W-1] ? (JUMP_W'(~v) + JUMP_W'(1)) : JUMP_W'(v);
    endfunction

endpackage

FILE: sv/tci_stream_if.sv
// ----------------------------------------------------------------------------
// tci_stream_if: valid/ready stream channel
// Carries one payload beat per cycle when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tci_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/tci_front.sv
// ----------------------------------------------------------------------------
// tci_front: cell window and classification pipeline
// Accepts cells, keeps the two previous cells, computes the flag of the
// middle cell over three stages and pushes a result command to the queue.
// ----------------------------------------------------------------------------
module tci_front
    import tci_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    tci_stream_if.sink cells,
    input  logic      room,
    output cmd_slot_t push
);

    logic accept;

    // cell window
    logic signed [AVG_W-1:0]   older_average_reg;
    logic signed [SLOPE_W-1:0] older_slope_reg;
    logic signed [AVG_W-1:0]   newer_average_reg;
    logic signed [SLOPE_W-1:0] newer_slope_reg;
    seen_t                     seen_reg;

    // stage 1: jumps and slope magnitudes
    logic signed [JUMP_W-1:0] s1_x1_next, s1_x2_next;
    logic                     s1_valid_reg;
    logic signed [JUMP_W-1:0] s1_x1_reg, s1_x2_reg;
    logic [MAG_W-1:0]         s1_mva_reg, s1_mvb_reg, s1_mvc_reg;
    seen_t                    s1_seen_reg;
    logic                     s1_last_reg;

    // stage 2: jump signs, coarse compare, ratio products
    logic [JUMP_W-1:0]  s2_a, s2_b;
    logic               s2_opp_next, s2_big_next;
    logic               s2_valid_reg;
    logic               s2_opp_reg, s2_big_reg;
    logic [CFG_W-1:0]   s2_a16_reg, s2_b16_reg;
    logic [PROD_W-1:0]  s2_pa_reg, s2_pb_reg, s2_pc_reg;
    logic [MAG_W-1:0]   s2_mva_reg, s2_mvb_reg, s2_mvc_reg;
    seen_t              s2_seen_reg;
    logic               s2_last_reg;

    // stage 3: flag, history and indicators
    logic [JPROD_W-1:0] jprod;
    logic [PROD_W-1:0]  qa, qb, qc;
    logic               a1, a2, a3, flag;
    logic [1:0]         hist_reg, hist_next;
    logic [1:0]         main_sum, tail_sum;
    logic [IND_W-1:0]   ind_main, ind_tail;

    assign cells.ready = room;
    assign accept      = cells.valid && room;

    always_comb
    begin
        s1_x1_next = JUMP_W'(older_average_reg) + (JUMP_W'(older_slope_reg) <<< 1)
                   - JUMP_W'(newer_average_reg);
        s1_x2_next = JUMP_W'($signed(cells.payload.cell_average))
                   - (JUMP_W'($signed(cells.payload.cell_slope)) <<< 1)
                   - JUMP_W'(newer_average_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            hist_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                if (cells.payload.last_cell)
                    seen_reg <= '0;
                else if (seen_reg != 2'd3)
                    seen_reg <= seen_reg + 2'd1;
            end
            if (s2_valid_reg)
                hist_reg <= s2_last_reg ? 2'd0 : hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_average_reg <= newer_average_reg;
            older_slope_reg   <= newer_slope_reg;
            newer_average_reg <= cells.payload.cell_average;
            newer_slope_reg   <= cells.payload.cell_slope;
            s1_x1_reg         <= s1_x1_next;
            s1_x2_reg         <= s1_x2_next;
            s1_mva_reg        <= slope_mag(older_slope_reg);
            s1_mvb_reg        <= slope_mag(newer_slope_reg);
            s1_mvc_reg        <= slope_mag(cells.payload.cell_slope);
            s1_seen_reg       <= seen_reg;
            s1_last_reg       <= cells.payload.last_cell;
        end
    end

    always_comb
    begin
        s2_a        = jump_mag(s1_x1_reg);
        s2_b        = jump_mag(s1_x2_reg);
        s2_opp_next = (s1_x1_reg != '0) && (s1_x2_reg != '0)
                   && (s1_x1_reg[JUMP_W-1] != s1_x2_reg[JUMP_W-1]);
        // either magnitude above T makes the product exceed T; otherwise both fit 16 bits
        s2_big_next = (s2_a > JUMP_W'(cfg.product_threshold))
                   || (s2_b > JUMP_W'(cfg.product_threshold));
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_opp_reg  <= s2_opp_next;
            s2_big_reg  <= s2_big_next;
            s2_a16_reg  <= s2_a[CFG_W-1:0];
            s2_b16_reg  <= s2_b[CFG_W-1:0];
            s2_pa_reg   <= PROD_W'(cfg.slope_ratio) * PROD_W'(s1_mva_reg);
            s2_pb_reg   <= PROD_W'(cfg.slope_ratio) * PROD_W'(s1_mvb_reg);
            s2_pc_reg   <= PROD_W'(cfg.slope_ratio) * PROD_W'(s1_mvc_reg);
            s2_mva_reg  <= s1_mva_reg;
            s2_mvb_reg  <= s1_mvb_reg;
            s2_mvc_reg  <= s1_mvc_reg;
            s2_seen_reg <= s1_seen_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    always_comb
    begin
        jprod = JPROD_W'(s2_a16_reg) * JPROD_W'(s2_b16_reg);
        a1    = s2_opp_reg && (s2_big_reg || (jprod > JPROD_W'(cfg.product_threshold)));
        qa    = PROD_W'({s2_mva_reg, 8'd0});
        qb    = PROD_W'({s2_mvb_reg, 8'd0});
        qc    = PROD_W'({s2_mvc_reg, 8'd0});
        a2    = (qb > s2_pa_reg) || (s2_pb_reg < qa);
        a3    = (qc > s2_pb_reg) || (s2_pc_reg < qb);

        // the first cell of a row is a boundary and counts as flagged
        if (s2_seen_reg == 2'd1)
            flag = 1'b1;
        else
            flag = a1 && (a2 || a3);

        hist_next = (s2_seen_reg != 2'd0) ? {hist_reg[0], flag} : hist_reg;

        main_sum = 2'(hist_reg[1]) + 2'(hist_reg[0]) + 2'(flag);
        ind_main = (s2_seen_reg == 2'd2) ? IND_BOUNDARY : {main_sum, 1'b0};

        // the final cell counts as flagged
        tail_sum = 2'(hist_next[1]) + 2'(hist_next[0]) + 2'd1;
        ind_tail = (s2_seen_reg == 2'd1) ? IND_BOUNDARY : {tail_sum, 1'b0};

        push.valid        = s2_valid_reg && (s2_last_reg || (s2_seen_reg >= 2'd2));
        push.cmd.row_last = s2_last_reg;
        push.cmd.count    = 2'd1;
        push.cmd.ind0     = ind_main;
        push.cmd.ind1     = IND_BOUNDARY;
        push.cmd.ind2     = IND_BOUNDARY;
        if (s2_last_reg)
        begin
            case (s2_seen_reg)
                2'd0:
                begin
                    push.cmd.count = 2'd1;
                    push.cmd.ind0  = IND_BOUNDARY;
                end
                2'd1:
                begin
                    push.cmd.count = 2'd2;
                    push.cmd.ind0  = ind_tail;
                end
                default:
                begin
                    push.cmd.count = 2'd3;
                    push.cmd.ind1  = ind_tail;
                end
            endcase
        end
    end

endmodule

FILE: sv/tci_queue.sv
// ----------------------------------------------------------------------------
// tci_queue: command queue between classification and result output
// Small FIFO of result commands; reports room for the in-flight stages.
// ----------------------------------------------------------------------------
module tci_queue
    import tci_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_slot_t push,
    input  logic      pop,
    output cmd_slot_t head,
    output logic      room
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [LW-1:0] ROOM_LIMIT = LW'(DEPTH - FRONT_STAGES);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0] level_reg;
    logic          do_pop;

    assign head.valid = (level_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;
    // keep a slot free for every cell still in the classification stages
    assign room       = (level_reg < ROOM_LIMIT);

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
            level_reg <= level_reg + LW'(push.valid) - LW'(do_pop);
        end
    end

endmodule

FILE: sv/tci_back.sv
// ----------------------------------------------------------------------------
// tci_back: result sequencer
// Walks the results of the head command one beat per cycle into the output
// register while the sink is ready.
// ----------------------------------------------------------------------------
module tci_back
    import tci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_slot_t   head,
    output logic        pop,
    tci_stream_if.source results
);

    logic [1:0]       slot_reg;
    logic             out_valid_reg;
    logic [IND_W-1:0] ind_reg;
    logic             last_reg;
    logic             load, final_slot;
    logic [IND_W-1:0] ind_sel;

    assign results.valid               = out_valid_reg;
    assign results.payload.indicator   = ind_reg;
    assign results.payload.last_result = last_reg;

    assign load       = head.valid && (!out_valid_reg || results.ready);
    assign final_slot = (slot_reg == head.cmd.count - 2'd1);
    assign pop        = load && final_slot;

    always_comb
    begin
        case (slot_reg)
            2'd0:    ind_sel = head.cmd.ind0;
            2'd1:    ind_sel = head.cmd.ind1;
            default: ind_sel = head.cmd.ind2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                slot_reg      <= final_slot ? 2'd0 : slot_reg + 2'd1;
            end
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ind_reg  <= ind_sel;
            last_reg <= head.cmd.row_last && final_slot;
        end
    end

endmodule

FILE: sv/troubled_cell_indicator_unit.sv
// ----------------------------------------------------------------------------
// troubled_cell_indicator_unit: troubled cell indicator for one grid row
// Flags cells whose neighbour jumps and slope ratios show a discontinuity.
// ----------------------------------------------------------------------------
// Cells stream in one per cycle while the queue has room; a row ends with
// a beat that has last_cell set. The indicator of cell k is produced once
// cell k+2 arrives, and the last cell of a row releases up to three
// indicators, which leave the output register one per cycle while the
// sink is ready. Classification is a three-stage pipeline (jump adds,
// 16x32 ratio products, jump product and compares) that feeds a queue of
// QUEUE_DEPTH commands; QUEUE_DEPTH must be at least 3, and at least 4 for
// one cell per cycle. Input is held off while fewer than three queue entries
// are free, one for each of the two classification stages and one for the
// arriving cell, and the output side drains at most one beat per cycle.
// Configuration is taken at any cycle but must only change while the unit
// is empty.
module troubled_cell_indicator_unit
    import tci_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    tci_stream_if.sink             cells,
    tci_stream_if.source           results
);

    cfg_t      cfg_reg;
    cmd_slot_t push;
    cmd_slot_t head;
    logic      room;
    logic      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slope_ratio       <= SLOPE_RATIO_RESET;
            cfg_reg.product_threshold <= PRODUCT_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLOPE_RATIO:       cfg_reg.slope_ratio       <= cfg_wdata;
                REG_PRODUCT_THRESHOLD: cfg_reg.product_threshold <= cfg_wdata;
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    tci_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .cells (cells),
        .room  (room),
        .push  (push)
    );

    tci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .room  (room)
    );

    tci_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

FILE: sim/tb_troubled_cell_indicator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_troubled_cell_indicator_unit: self-checking bench of the indicator unit
// Streams rows of cells through the unit with random gaps and output stalls,
// predicts every indicator beat from its own model of the three-cell window,
// and compares each output beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_troubled_cell_indicator_unit;

    import tci_pkg::*;

    localparam int SETTLE_CYCLES = FRONT_STAGES + 14;
    localparam int RANDOM_ITEMS  = 75;

    typedef enum int {
        ROW_SMOOTH,
        ROW_STEP,
        ROW_NOISE,
        ROW_EXTREME
    } row_shape_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    tci_stream_if #(.payload_t(cell_beat_t))   cells_if ();
    tci_stream_if #(.payload_t(result_beat_t)) results_if ();

    troubled_cell_indicator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cells     (cells_if),
        .results   (results_if)
    );

    // window model: cell k-2, cell k-1, flags of k-2 and k-3, row position
    logic signed [AVG_W-1:0]   two_back_avg   = '0;
    logic signed [SLOPE_W-1:0] two_back_slope = '0;
    logic signed [AVG_W-1:0]   one_back_avg   = '0;
    logic signed [SLOPE_W-1:0] one_back_slope = '0;
    logic [1:0]                flag_bits      = '0;
    int                        row_position   = 0;
    logic [CFG_W-1:0]          ratio_q88      = SLOPE_RATIO_RESET;
    logic [CFG_W-1:0]          product_limit  = PRODUCT_THRESHOLD_RESET;

    result_beat_t expected_indicators[$];
    result_beat_t oldest;
    int unsigned  mismatch_count = 0;
    bit           steady_flow    = 1'b0;
    int           sink_hold      = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll = $urandom_range(0, 99);
        if (steady_flow || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 24);
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // true when the slope pair (p, q) lies outside the allowed ratio
    function automatic bit ratio_breaks(longint p, longint q);
        longint unsigned ap, aq, sr;
        ap = magnitude(p);
        aq = magnitude(q);
        sr = ratio_q88;
        return (aq * 256 > sr * ap) || (sr * aq < ap * 256);
    endfunction

    // true when x1 * x2 < -threshold
    function automatic bit jumps_oppose(longint x1, longint x2);
        longint unsigned a, b, t;
        t = product_limit;
        if (x1 == 0 || x2 == 0 || ((x1 < 0) == (x2 < 0)))
            return 1'b0;
        a = magnitude(x1);
        b = magnitude(x2);
        if (a > t)
            return 1'b1;
        return a * b > t;
    endfunction

    function automatic result_beat_t indicator_beat(int value, logic last);
        result_beat_t r;
        r.indicator   = IND_W'(value);
        r.last_result = last;
        return r;
    endfunction

    task automatic predict_indicators(input cell_beat_t beat);
        longint     ua, va, ub, vb, uc, vc, x1, x2;
        logic [1:0] hist;
        logic       flag;
        int         flag_sum;
        ua   = two_back_avg;
        va   = two_back_slope;
        ub   = one_back_avg;
        vb   = one_back_slope;
        uc   = beat.cell_average;
        vc   = beat.cell_slope;
        hist = flag_bits;
        if (row_position >= 1)
        begin
            if (row_position == 1)
                flag = 1'b1;
            else
            begin
                x1   = ua + 2 * va - ub;
                x2   = uc - 2 * vc - ub;
                flag = jumps_oppose(x1, x2) && (ratio_breaks(va, vb) || ratio_breaks(vb, vc));
            end
            if (row_position == 2)
                expected_indicators.push_back(indicator_beat(IND_BOUNDARY, 1'b0));
            else if (row_position > 2)
            begin
                flag_sum = hist[1] + hist[0] + flag;
                expected_indicators.push_back(indicator_beat(2 * flag_sum, 1'b0));
            end
            hist = {hist[0], flag};
        end
        if (beat.last_cell)
        begin
            // flush: the cell before the last one, then the last one itself
            if (row_position == 1)
                expected_indicators.push_back(indicator_beat(IND_BOUNDARY, 1'b0));
            else if (row_position > 1)
            begin
                flag_sum = hist[1] + hist[0] + 1;
                expected_indicators.push_back(indicator_beat(2 * flag_sum, 1'b0));
            end
            expected_indicators.push_back(indicator_beat(IND_BOUNDARY, 1'b1));
            two_back_avg   = '0;
            two_back_slope = '0;
            one_back_avg   = '0;
            one_back_slope = '0;
            flag_bits      = '0;
            row_position   = 0;
        end
        else
        begin
            two_back_avg   = one_back_avg;
            two_back_slope = one_back_slope;
            one_back_avg   = beat.cell_average;
            one_back_slope = beat.cell_slope;
            flag_bits      = hist;
            if (row_position < 3)
                row_position++;
        end
    endtask

    // predict on every accepted cell, check every accepted indicator
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cells_if.valid && cells_if.ready)
                predict_indicators(cells_if.payload);
            if (results_if.valid && results_if.ready)
            begin
                if (expected_indicators.size() == 0)
                begin
                    $display("%0t: indicator beat with nothing expected, got %0d last %0d",
                             $time, results_if.payload.indicator,
                             results_if.payload.last_result);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_indicators.pop_front();
                    if (oldest.indicator !== results_if.payload.indicator)
                    begin
                        $display("%0t: indicator mismatch, expected %0d, got %0d",
                                 $time, oldest.indicator, results_if.payload.indicator);
                        mismatch_count++;
                    end
                    if (oldest.last_result !== results_if.payload.last_result)
                    begin
                        $display("%0t: last_result mismatch, expected %0d, got %0d",
                                 $time, oldest.last_result, results_if.payload.last_result);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // output side: random stalls of mixed length
    always @(posedge clk)
    begin
        if (sink_hold == 0 && !steady_flow && $urandom_range(0, 3) == 0)
            sink_hold = pick_gap();
        if (sink_hold != 0)
        begin
            sink_hold--;
            results_if.ready <= 1'b0;
        end
        else
            results_if.ready <= 1'b1;
    end

    function automatic cell_beat_t make_cell(logic [31:0] avg, logic [31:0] slope, logic last);
        cell_beat_t beat;
        beat.cell_average = avg;
        beat.cell_slope   = slope;
        beat.last_cell    = last;
        return beat;
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 4))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // one beat; valid stays high after acceptance unless a gap follows
    task automatic send_cell(input cell_beat_t beat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cells_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cells_if.valid   <= 1'b1;
        cells_if.payload <= beat;
        @(posedge clk);
        while (!cells_if.ready)
            @(posedge clk);
    endtask

    // drop valid and hold until every predicted beat is out and the pipe is empty
    task automatic wait_until_idle();
        cells_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_indicators.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input logic [CFG_W-1:0] sr, input logic [CFG_W-1:0] thr);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SLOPE_RATIO;
        cfg_wdata <= sr;
        @(posedge clk);
        cfg_index <= REG_PRODUCT_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we        <= 1'b0;
        ratio_q88     = sr;
        product_limit = thr;
    endtask

    task automatic send_row(input int length, input row_shape_t shape, input int pause_at);
        cell_beat_t beat;
        int         level, jump_level, split;
        level      = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        jump_level = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        split      = $urandom_range(0, length);
        for (int k = 0; k < length; k++)
        begin
            if (k == pause_at)
                wait_until_idle();
            case (shape)
                ROW_SMOOTH:
                begin
                    beat.cell_average = level + int'($urandom_range(0, 4095)) - 2048;
                    beat.cell_slope   = int'($urandom_range(0, 8191)) - 4096;
                end
                ROW_STEP:
                begin
                    beat.cell_average = (k < split) ? level : jump_level;
                    beat.cell_slope   = int'($urandom_range(0, 131071)) - 65536;
                end
                ROW_NOISE:
                begin
                    beat.cell_average = $urandom;
                    beat.cell_slope   = $urandom;
                end
                default:
                begin
                    beat.cell_average = extreme_word();
                    beat.cell_slope   = extreme_word();
                end
            endcase
            beat.last_cell = (k == length - 1);
            send_cell(beat);
        end
    endtask

    task automatic test_short_rows();
        send_cell(make_cell(32'h0001_0000, 32'h0000_8000, 1'b1));
        send_cell(make_cell(32'h0002_0000, 32'hffff_0000, 1'b0));
        send_cell(make_cell(32'hfffe_0000, 32'h0000_0000, 1'b1));
        send_cell(make_cell(32'h0000_0000, 32'h0001_0000, 1'b0));
        send_cell(make_cell(32'h0005_0000, 32'h0000_0000, 1'b0));
        send_cell(make_cell(32'h0000_0000, 32'h0001_0000, 1'b1));
    endtask

    task automatic test_zero_jumps();
        send_cell(make_cell(32'h0, 32'h0, 1'b0));
        send_cell(make_cell(32'h0, 32'h0, 1'b0));
        send_cell(make_cell(32'h0, 32'h0, 1'b1));
    endtask

    // product of -1 and the threshold sits on the limit; one more crosses it
    task automatic test_jump_threshold();
        logic [31:0] limit;
        limit = product_limit;
        send_cell(make_cell(32'hffff_ffff, 32'h0, 1'b0));
        send_cell(make_cell(32'h0, 32'h0001_0000, 1'b0));
        send_cell(make_cell(limit, 32'h0, 1'b1));
        send_cell(make_cell(32'hffff_ffff, 32'h0, 1'b0));
        send_cell(make_cell(32'h0, 32'h0001_0000, 1'b0));
        send_cell(make_cell(limit + 1, 32'h0, 1'b1));
    endtask

    task automatic test_extreme_values();
        send_cell(make_cell(32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 1'b0));
        send_cell(make_cell(32'h7fff_ffff, 32'h8000_0000, 1'b0));
        send_cell(make_cell(32'h8000_0000, 32'h7fff_ffff, 1'b0));
        send_cell(make_cell(32'h0, 32'hffff_ffff, 1'b1));
    endtask

    // a clean step between two levels, with a slope that points the wrong way
    task automatic test_step_profile();
        send_cell(make_cell(32'h0, 32'h0, 1'b0));
        send_cell(make_cell(32'h0, 32'hffff_0000, 1'b0));
        send_cell(make_cell(32'h0, 32'h0, 1'b0));
        send_cell(make_cell(32'h0008_0000, 32'h0, 1'b0));
        send_cell(make_cell(32'h0008_0000, 32'h0, 1'b1));
    endtask

    task automatic test_register_extremes();
        logic [CFG_W-1:0] ratios[4]     = '{16'd0, 16'hffff, 16'd0, 16'hffff};
        logic [CFG_W-1:0] thresholds[4] = '{16'd0, 16'hffff, 16'hffff, 16'd0};
        for (int s = 0; s < 4; s++)
        begin
            wait_until_idle();
            program_registers(ratios[s], thresholds[s]);
            send_row($urandom_range(3, 5), ROW_STEP, -1);
            send_row($urandom_range(3, 5), row_shape_t'($urandom_range(0, 3)), -1);
        end
    endtask

    task automatic test_random_rows();
        int               sent, length, pause_at;
        bit               pressure_done;
        row_shape_t       shape;
        logic [CFG_W-1:0] sr, thr;
        sent          = 0;
        pressure_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                sr  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                  : CFG_W'($urandom_range(128, 1024));
                thr = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom)
                                                  : CFG_W'($urandom_range(0, 1024));
                wait_until_idle();
                program_registers(sr, thr);
            end
            length   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            shape    = row_shape_t'($urandom_range(0, 3));
            pause_at = -1;
            // pause mid-row once, with the window half full
            if (!pressure_done && length >= 4)
            begin
                pause_at      = length / 2;
                pressure_done = 1'b1;
            end
            steady_flow = ($urandom_range(0, 4) == 0);
            send_row(length, shape, pause_at);
            sent += length;
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_SLOPE_RATIO;
        cfg_wdata          = '0;
        cells_if.valid     = 1'b0;
        cells_if.payload   = '0;
        results_if.ready   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_rows();
        test_zero_jumps();
        test_jump_threshold();
        test_extreme_values();
        test_step_profile();
        test_register_extremes();
        wait_until_idle();
        program_registers(SLOPE_RATIO_RESET, PRODUCT_THRESHOLD_RESET);
        test_random_rows();

        wait_until_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
